// File: sv/masked_local_deviation_filter_assert.svh
// Assertion macros for the masked local deviation filter
`ifndef MASKED_LOCAL_DEVIATION_FILTER_ASSERT_SVH
`define MASKED_LOCAL_DEVIATION_FILTER_ASSERT_SVH

// same-cycle implication
`define MLDF_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define MLDF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: sv/mldf_pkg.sv
// Shared types and constants of the masked local deviation filter
`default_nettype none

package mldf_pkg;

   localparam int MAX_WIN     = 5;
   localparam int PIX_BITS    = 8;
   localparam int LINES       = MAX_WIN - 1;
   localparam int LINE_SEL_W  = $clog2(LINES);
   localparam int NUM_W       = MAX_WIN * MAX_WIN;
   localparam int WIDX_W      = $clog2(NUM_W);
   localparam int MAX_HEIGHT  = 4096;
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int DIM_W       = 13;
   localparam int WIN_DIM_W   = 3;
   localparam int CNT_N_W     = $clog2(NUM_W + 1);
   localparam int DIV_W       = 28;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CSR_IMG_WIDTH  = 3'd0,
      CSR_IMG_HEIGHT = 3'd1,
      CSR_WIN_WIDTH  = 3'd2,
      CSR_WIN_HEIGHT = 3'd3,
      CSR_WEIGHTS_A  = 3'd4,
      CSR_WEIGHTS_B  = 3'd5,
      CSR_WEIGHTS_C  = 3'd6,
      CSR_WEIGHTS_D  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                cmd;
      logic [PIX_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_out;
      logic                is_border;
      logic                frame_end;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]                  width;
      logic [DIM_W-1:0]                  height;
      logic [WIN_DIM_W-1:0]              win_w;
      logic [WIN_DIM_W-1:0]              win_h;
      logic [NUM_W-1:0][PIX_BITS-1:0]    weights;
   } cfg_type;

   // one classified result on its way to the back end
   typedef struct packed {
      logic                           compute;
      logic                           fend;
      logic [PIX_BITS-1:0]            value;
      logic [NUM_W-1:0][PIX_BITS-1:0] win;
   } job_type;

endpackage

`default_nettype wire

// File: sv/mldf_div.sv
// Restoring divider, one quotient bit per cycle, small unsigned divisor
`default_nettype none

module mldf_div
   import mldf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_W-1:0]   dividend,
   input  wire logic [CNT_N_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(DIV_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DIV_W-1:0]   q_ff, q_in;
   logic [CNT_N_W-1:0] r_ff, r_in;
   logic [CNT_N_W-1:0] d_ff, d_in;
   logic [CNT_N_W:0]   r_sh;
   logic               ge;

   always_comb begin
      r_sh    = {r_ff, q_ff[DIV_W-1]};
      ge      = r_sh >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         q_in    = {q_ff[DIV_W-2:0], ge};
         r_in    = ge ? CNT_N_W'(r_sh - {1'b0, d_ff}) : r_sh[CNT_N_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: sv/mldf_queue.sv
// Short job queue between the front end and the back end
`default_nettype none

module mldf_queue
   import mldf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: sv/mldf_front.sv
// Front end: line buffers, window, raster bookkeeping and border classification
`default_nettype none

module mldf_front
   import mldf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   input  wire cfg_type cfg,
   input  wire logic    restart,
   output logic         q_push,
   output job_type      q_job,
   input  wire logic    q_full
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   typedef enum logic {FR_IDLE, FR_WORK} fr_state_type;

   fr_state_type                   state_ff, state_in;
   logic                           cmd_ff, cmd_in;
   logic [PIX_BITS-1:0]            px_ff, px_in;
   logic [CW-1:0]                  in_col_ff, in_col_in;
   logic [ROW_W-1:0]               in_row_ff, in_row_in;
   logic [CW-1:0]                  out_col_ff, out_col_in;
   logic [ROW_W-1:0]               out_row_ff, out_row_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           tail_ff, tail_in;
   logic [NUM_W-1:0][PIX_BITS-1:0] win_ff, win_in;

   logic [PIX_BITS-1:0]            line_mem [LINES][MAX_WIDTH];
   logic [PIX_BITS-1:0]            rd_ff [LINES];
   logic                           accept, rd_en, wr_en;
   logic [CW-1:0]                  rd_addr;

   logic [NUM_W-1:0][PIX_BITS-1:0] win_new;
   logic [CW-1:0]                  ocol;
   logic [ROW_W-1:0]               orow;
   logic [WIN_DIM_W-1:0]           hx, hy, ax, ay;
   logic [CNT_W-1:0]               lag;
   logic                           o_last, in_last, interior, emit;
   logic [DIM_W-1:0]               wm1, hm1, k_line;
   logic [WIDX_W-1:0]              bidx;
   logic [PIX_BITS-1:0]            value;

   assign accept  = push && !full;
   assign full    = (state_ff != FR_IDLE) || q_full;
   assign rd_en   = accept;
   assign rd_addr = req_data.cmd ? out_col_ff : in_col_ff;
   assign wr_en   = (state_ff == FR_WORK) && !cmd_ff;

   // line k holds the pixel k+1 rows above the incoming one
   always_ff @(posedge clock) begin
      for (int k = 0; k < LINES; k++) begin
         if (wr_en) begin
            line_mem[k][in_col_ff] <= (k == 0) ? px_ff : rd_ff[(k == 0) ? 0 : k - 1];
         end
         if (rd_en) begin
            rd_ff[k] <= line_mem[k][rd_addr];
         end
      end
   end

   always_comb begin
      wm1 = cfg.width - 1'b1;
      hm1 = cfg.height - 1'b1;
      hx  = (cfg.win_w - 1'b1) >> 1;
      hy  = (cfg.win_h - 1'b1) >> 1;
      ax  = cfg.win_w >> 1;
      ay  = cfg.win_h >> 1;
      lag = CNT_W'(ay) * CNT_W'(cfg.width) + CNT_W'(ax);

      for (int r = 0; r < MAX_WIN; r++) begin
         for (int c = 0; c < MAX_WIN - 1; c++) begin
            win_new[r*MAX_WIN + c] = win_ff[r*MAX_WIN + c + 1];
         end
      end
      win_new[NUM_W-1] = px_ff;
      for (int k = 0; k < LINES; k++) begin
         win_new[(MAX_WIN - 2 - k)*MAX_WIN + MAX_WIN - 1] = rd_ff[k];
      end

      // a pending tail is dropped when the next frame starts
      ocol = (!cmd_ff && tail_ff) ? '0 : out_col_ff;
      orow = (!cmd_ff && tail_ff) ? '0 : out_row_ff;

      o_last   = (DIM_W'(orow) == hm1) && (DIM_W'(ocol) == wm1);
      in_last  = (DIM_W'(in_row_ff) == hm1) && (DIM_W'(in_col_ff) == wm1);
      interior = (DIM_W'(orow) >= DIM_W'(hy)) && (DIM_W'(orow) + DIM_W'(ay) <= hm1)
               && (DIM_W'(ocol) >= DIM_W'(hx)) && (DIM_W'(ocol) + DIM_W'(ax) <= wm1);
      bidx     = WIDX_W'(3'(MAX_WIN - 1) - ay) * WIDX_W'(MAX_WIN)
               + WIDX_W'(3'(MAX_WIN - 1) - ax);
      k_line   = hm1 - DIM_W'(orow);

      if (cmd_ff) begin
         emit  = tail_ff;
         value = (k_line < DIM_W'(LINES)) ? rd_ff[k_line[LINE_SEL_W-1:0]] : '0;
      end else begin
         emit  = cnt_ff >= lag;
         value = win_new[bidx];
      end

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      px_in      = px_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      cnt_in     = cnt_ff;
      tail_in    = tail_ff;
      win_in     = win_ff;
      q_push     = 1'b0;

      q_job.compute = !cmd_ff && interior;
      q_job.fend    = o_last;
      q_job.value   = value;
      q_job.win     = win_new;

      if (state_ff == FR_IDLE) begin
         if (accept) begin
            state_in = FR_WORK;
            cmd_in   = req_data.cmd;
            px_in    = req_data.pixel_in;
         end
      end else begin
         state_in = FR_IDLE;
         q_push   = emit;
         if (emit) begin
            if (o_last) begin
               out_col_in = '0;
               out_row_in = '0;
            end else if (DIM_W'(ocol) == wm1) begin
               out_col_in = '0;
               out_row_in = orow + 1'b1;
            end else begin
               out_col_in = ocol + 1'b1;
               out_row_in = orow;
            end
         end else if (!cmd_ff) begin
            out_col_in = ocol;
            out_row_in = orow;
         end
         if (cmd_ff) begin
            if (emit && o_last) begin
               tail_in = 1'b0;
            end
         end else begin
            win_in = win_new;
            if (in_last) begin
               in_col_in = '0;
               in_row_in = '0;
               cnt_in    = '0;
               tail_in   = !(emit && o_last);
            end else begin
               tail_in = 1'b0;
               cnt_in  = emit ? cnt_ff : cnt_ff + 1'b1;
               if (DIM_W'(in_col_ff) == wm1) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + 1'b1;
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end
         end
      end

      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         cnt_in     = '0;
         tail_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         cnt_ff     <= '0;
         tail_ff    <= 1'b0;
         win_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         cnt_ff     <= cnt_in;
         tail_ff    <= tail_in;
         win_ff     <= win_in;
      end
      cmd_ff <= cmd_in;
      px_ff  <= px_in;
   end

endmodule

`default_nettype wire

// File: sv/mldf_back.sv
// Back end: weighted mean, squared deviations, square root, scaling, result register
`default_nettype none

module mldf_back
   import mldf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire job_type q_head,
   input  wire logic    q_empty,
   output logic         q_pop,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   localparam int ACC_W  = 54;
   localparam int ROOT_W = ACC_W / 2;
   localparam int REM_W  = ROOT_W + 1;
   localparam int IT_W   = $clog2(ROOT_W);

   typedef enum logic [3:0] {
      BK_IDLE, BK_SUM, BK_MEAN, BK_SQ, BK_DRAIN1, BK_DRAIN2,
      BK_ROOT_LOAD, BK_ROOT, BK_SCALE, BK_DONE
   } bk_state_type;

   bk_state_type                   state_ff, state_in;
   logic [NUM_W-1:0][PIX_BITS-1:0] win_ff, win_in;
   logic                           fend_ff, fend_in;
   logic [WIN_DIM_W-1:0]           i_ff, i_in, j_ff, j_in;
   logic [WIDX_W-1:0]              n_ff, n_in;
   logic signed [20:0]             sum_ff, sum_in;
   logic [CNT_N_W-1:0]             cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic signed [DIV_W:0]          mean_ff, mean_in;
   logic signed [16:0]             t_ff;
   logic                           tv_ff, tv_in;
   logic [47:0]                    sq_ff;
   logic                           sqv_ff;
   logic [ACC_W-1:0]               acc_ff, acc_in;
   logic [ACC_W-1:0]               src_ff, src_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [ROOT_W-1:0]              root_ff, root_in;
   logic [IT_W-1:0]                it_ff, it_in;
   logic [PIX_BITS-1:0]            res_ff, res_in;
   logic                           out_valid_ff, out_valid_in;
   rsp_type                        out_ff, out_in;

   logic                           div_start, div_done;
   logic [DIV_W-1:0]               div_dividend, div_quot;

   logic [WIN_DIM_W-1:0]           row, col;
   logic [WIDX_W-1:0]              pidx;
   logic [PIX_BITS-1:0]            px, w;
   logic signed [16:0]             px_s, w_s, t;
   logic                           last_elem, out_free;
   logic [20:0]                    sum_mag;
   logic signed [29:0]             d;
   logic [29:0]                    d_abs;
   logic [23:0]                    m;
   logic [47:0]                    sq;
   logic [REM_W+1:0]               rem_sh, trial;

   mldf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      // element (i, j) of the mask sits at the lower right of the window
      row  = 3'(MAX_WIN) - cfg.win_h + i_ff;
      col  = 3'(MAX_WIN) - cfg.win_w + j_ff;
      pidx = WIDX_W'(row) * WIDX_W'(MAX_WIN) + WIDX_W'(col);
      px   = win_ff[pidx];
      w    = cfg.weights[n_ff];
      px_s = {9'b0, px};
      w_s  = {{9{w[7]}}, w};
      t    = px_s * w_s;
      last_elem = (i_ff == cfg.win_h - 1'b1) && (j_ff == cfg.win_w - 1'b1);

      d     = {{5{t_ff[16]}}, t_ff, 8'b0} - {mean_ff[DIV_W], mean_ff};
      d_abs = d[29] ? 30'(-d) : 30'(d);
      m     = d_abs[23:0];
      sq    = 48'(m) * 48'(m);

      rem_sh = {rem_ff, src_ff[ACC_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};

      out_free = !out_valid_ff || pop;

      state_in     = state_ff;
      win_in       = win_ff;
      fend_in      = fend_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      tv_in        = 1'b0;
      acc_in       = sqv_ff ? acc_ff + ACC_W'(sq_ff) : acc_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      it_in        = it_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      sum_mag      = sum_ff[20] ? 21'(-sum_ff) : 21'(sum_ff);
      div_dividend = {sum_mag[19:0], 8'b0};

      if (state_ff == BK_SUM || state_ff == BK_SQ) begin
         n_in = n_ff + 1'b1;
         if (j_ff == cfg.win_w - 1'b1) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (!q_head.compute) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     out_valid_in = 1'b1;
                     out_in       = '{pixel_out: q_head.value, is_border: 1'b1,
                                      frame_end: q_head.fend};
                  end
               end else begin
                  q_pop    = 1'b1;
                  win_in   = q_head.win;
                  fend_in  = q_head.fend;
                  i_in     = '0;
                  j_in     = '0;
                  n_in     = '0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = BK_SUM;
               end
            end
         end
         BK_SUM: begin
            sum_in = sum_ff + {{4{t[16]}}, t};
            cnt_in = cnt_ff + CNT_N_W'(w != '0);
            if (last_elem) begin
               state_in = BK_MEAN;
            end
         end
         BK_MEAN: begin
            // first cycle here launches the divide, later cycles wait for it
            if (n_ff != '0) begin
               if (cnt_ff == '0) begin
                  res_in   = '0;
                  state_in = BK_DONE;
               end else begin
                  div_start = 1'b1;
                  neg_in    = sum_ff[20];
                  n_in      = '0;
               end
            end else if (div_done) begin
               mean_in  = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
               i_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               state_in = BK_SQ;
            end
         end
         BK_SQ: begin
            tv_in = w != '0;
            if (last_elem) begin
               state_in = BK_DRAIN1;
            end
         end
         BK_DRAIN1: begin
            state_in = BK_DRAIN2;
         end
         BK_DRAIN2: begin
            state_in = BK_ROOT_LOAD;
         end
         BK_ROOT_LOAD: begin
            src_in   = acc_ff;
            rem_in   = '0;
            root_in  = '0;
            it_in    = '0;
            state_in = BK_ROOT;
         end
         BK_ROOT: begin
            src_in = {src_ff[ACC_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            it_in = it_ff + 1'b1;
            if (it_ff == IT_W'(ROOT_W - 1)) begin
               n_in     = '1;
               state_in = BK_SCALE;
            end
         end
         BK_SCALE: begin
            div_dividend = DIV_W'(root_ff[ROOT_W-1:8]);
            if (n_ff != '0) begin
               div_start = 1'b1;
               n_in      = '0;
            end else if (div_done) begin
               res_in   = (div_quot > DIV_W'(255)) ? 8'hFF : div_quot[7:0];
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{pixel_out: res_ff, is_border: 1'b0, frame_end: fend_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         tv_ff        <= 1'b0;
         sqv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         tv_ff        <= tv_in;
         sqv_ff       <= tv_ff;
      end
      win_ff  <= win_in;
      fend_ff <= fend_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mean_ff <= mean_in;
      t_ff    <= t;
      sq_ff   <= sq;
      acc_ff  <= acc_in;
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      it_ff   <= it_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

`default_nettype wire

// File: sv/masked_local_deviation_filter.sv
// Top level: register file, front end, job queue and back end
//
// Pixels enter in raster order through push/full with req_data (cmd 0 = pixel,
// cmd 1 = flush one pending result of the frame tail). Results leave through
// empty/pop with rsp_data, oldest first. Registers are written through
// csr_we/csr_index/csr_wdata; a geometry write restarts the stream.
// The front end is busy with each transaction before it takes the next: the
// accepting cycle reads the four line buffer banks, the cycle after shifts the
// window, writes the banks back and classifies the result position. A border
// or flush result then passes through the job queue to the result register.
// An interior pixel runs through the back end in two passes over the mask,
// two divides on a shared divider and a 27-step square root. These jobs set
// the sustained rate; border pixels pass at the front end rate.
// A two-entry queue lets the front end keep accepting while the back end
// works; full rises when that queue is full or the front end is busy.
// While pop stays low the back end holds its finished result and stalls.
// Reset clears all control state and loads the default registers; the line
// buffers need no clearing.
`default_nettype none

`include "masked_local_deviation_filter_assert.svh"

module masked_local_deviation_filter
   import mldf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   logic [DIM_W-1:0]               img_width_ff, img_height_ff;
   logic [WIN_DIM_W-1:0]           win_width_ff, win_height_ff;
   logic [NUM_W-1:0][PIX_BITS-1:0] weights_ff;

   cfg_type cfg;
   logic    restart;
   logic    q_push, q_full, q_pop, q_empty;
   job_type q_job, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= DIM_W'(640);
         img_height_ff <= DIM_W'(480);
         win_width_ff  <= WIN_DIM_W'(3);
         win_height_ff <= WIN_DIM_W'(3);
         for (int n = 0; n < NUM_W; n++) begin
            weights_ff[n] <= PIX_BITS'(1);
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMG_WIDTH:  img_width_ff      <= csr_wdata[DIM_W-1:0];
            CSR_IMG_HEIGHT: img_height_ff     <= csr_wdata[DIM_W-1:0];
            CSR_WIN_WIDTH:  win_width_ff      <= csr_wdata[WIN_DIM_W-1:0];
            CSR_WIN_HEIGHT: win_height_ff     <= csr_wdata[WIN_DIM_W-1:0];
            CSR_WEIGHTS_A:  weights_ff[7:0]   <= csr_wdata;
            CSR_WEIGHTS_B:  weights_ff[15:8]  <= csr_wdata;
            CSR_WEIGHTS_C:  weights_ff[23:16] <= csr_wdata;
            CSR_WEIGHTS_D:  weights_ff[24]    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = csr_we && (csr_index_type'(csr_index) inside
                {CSR_IMG_WIDTH, CSR_IMG_HEIGHT, CSR_WIN_WIDTH, CSR_WIN_HEIGHT});

      if (img_width_ff == '0) begin
         cfg.width = DIM_W'(1);
      end else if (img_width_ff > MAX_WIDTH) begin
         cfg.width = DIM_W'(MAX_WIDTH);
      end else begin
         cfg.width = img_width_ff;
      end
      if (img_height_ff == '0) begin
         cfg.height = DIM_W'(1);
      end else if (img_height_ff > MAX_HEIGHT) begin
         cfg.height = DIM_W'(MAX_HEIGHT);
      end else begin
         cfg.height = img_height_ff;
      end
      if (win_width_ff == '0) begin
         cfg.win_w = WIN_DIM_W'(1);
      end else if (win_width_ff > MAX_WIN) begin
         cfg.win_w = WIN_DIM_W'(MAX_WIN);
      end else begin
         cfg.win_w = win_width_ff;
      end
      if (win_height_ff == '0) begin
         cfg.win_h = WIN_DIM_W'(1);
      end else if (win_height_ff > MAX_WIN) begin
         cfg.win_h = WIN_DIM_W'(MAX_WIN);
      end else begin
         cfg.win_h = win_height_ff;
      end
      cfg.weights = weights_ff;
   end

   mldf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cfg      (cfg),
      .restart  (restart),
      .q_push   (q_push),
      .q_job    (q_job),
      .q_full   (q_full)
   );

   mldf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   mldf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   `MLDF_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_push, !q_full,
      "job pushed into a full queue")
   `MLDF_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, q_pop, !q_empty,
      "job popped from an empty queue")
   `MLDF_ASSERT_NEXT(a_busy_after_accept, clock, reset, push && !full, full,
      "front end accepted a transaction while still working on one")

endmodule

`default_nettype wire
